### rtl/ifa_pkg.sv
// shared types, constants and control store for the integer to ascii formatter
`timescale 1ns / 1ps
`default_nettype none

package ifa_pkg;

   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 7;
   localparam int NUM_DIGITS  = 10;
   localparam int BCD_W       = 4 * NUM_DIGITS;
   localparam int COUNT_W     = $clog2(NUM_DIGITS + 1);
   localparam int ITER_W      = $clog2(VALUE_W);
   localparam int PC_W        = 4;
   localparam int FOUR_DIGITS = 4;
   localparam int BIN_DIGITS  = 8;
   localparam int HEX_DIGITS  = 2;
   // bcd value padded so every digit index stays in range
   localparam int PAD_W       = 64;

   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_X       = 7'h58;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;
   // 'A' minus ten
   localparam logic [CHAR_W-1:0] CHAR_HEX_OFS = 7'h37;

   typedef enum logic [1:0] {
      ACT_DEC  = 2'd0,
      ACT_BIN  = 2'd1,
      ACT_HEX  = 2'd2,
      ACT_FOUR = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [6:0] char_code;
      logic       last_char;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_DABBLE,
      OP_TRIM,
      OP_LIT,
      OP_DIGIT
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_HEX,
      C_BIN,
      C_FOUR,
      C_POS,
      C_MORE_ITER,
      C_NO_LEAD,
      C_MORE_DIG
   } cond_type;

   typedef struct packed {
      op_type          op;
      logic [CHAR_W-1:0] lit;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   // sequencer to datapath
   typedef struct packed {
      op_type            op;
      logic [CHAR_W-1:0] lit;
      logic              fire;
   } ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      action_type action;
      logic       neg;
      logic       iter_last;
      logic       lead_zero;
      logic       count_one;
   } status_type;

   localparam logic [PC_W-1:0] STEP_ACCEPT = 4'd0;
   localparam logic [PC_W-1:0] STEP_IS_HEX = 4'd1;
   localparam logic [PC_W-1:0] STEP_IS_BIN = 4'd2;
   localparam logic [PC_W-1:0] STEP_DABBLE = 4'd3;
   localparam logic [PC_W-1:0] STEP_IS_4D  = 4'd4;
   localparam logic [PC_W-1:0] STEP_SIGN   = 4'd5;
   localparam logic [PC_W-1:0] STEP_MINUS  = 4'd6;
   localparam logic [PC_W-1:0] STEP_LEAD   = 4'd7;
   localparam logic [PC_W-1:0] STEP_TRIM   = 4'd8;
   localparam logic [PC_W-1:0] STEP_DIGIT  = 4'd9;
   localparam logic [PC_W-1:0] STEP_END    = 4'd10;
   localparam logic [PC_W-1:0] STEP_HEX0   = 4'd11;
   localparam logic [PC_W-1:0] STEP_HEXX   = 4'd12;

   // control store: op runs until it completes, then jump on cond or fall through
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{op: OP_NOP, lit: CHAR_ZERO, cond: C_ALWAYS, target: STEP_ACCEPT};
      case (pc)
         STEP_ACCEPT: w = '{op: OP_ACCEPT, lit: CHAR_ZERO, cond: C_NEVER,
                            target: STEP_ACCEPT};
         STEP_IS_HEX: w = '{op: OP_NOP, lit: CHAR_ZERO, cond: C_HEX, target: STEP_HEX0};
         STEP_IS_BIN: w = '{op: OP_NOP, lit: CHAR_ZERO, cond: C_BIN, target: STEP_DIGIT};
         STEP_DABBLE: w = '{op: OP_DABBLE, lit: CHAR_ZERO, cond: C_MORE_ITER,
                            target: STEP_DABBLE};
         STEP_IS_4D:  w = '{op: OP_NOP, lit: CHAR_ZERO, cond: C_FOUR, target: STEP_DIGIT};
         STEP_SIGN:   w = '{op: OP_NOP, lit: CHAR_ZERO, cond: C_POS, target: STEP_LEAD};
         STEP_MINUS:  w = '{op: OP_LIT, lit: CHAR_MINUS, cond: C_NEVER,
                            target: STEP_ACCEPT};
         STEP_LEAD:   w = '{op: OP_NOP, lit: CHAR_ZERO, cond: C_NO_LEAD,
                            target: STEP_DIGIT};
         STEP_TRIM:   w = '{op: OP_TRIM, lit: CHAR_ZERO, cond: C_ALWAYS, target: STEP_LEAD};
         STEP_DIGIT:  w = '{op: OP_DIGIT, lit: CHAR_ZERO, cond: C_MORE_DIG,
                            target: STEP_DIGIT};
         STEP_END:    w = '{op: OP_NOP, lit: CHAR_ZERO, cond: C_ALWAYS,
                            target: STEP_ACCEPT};
         STEP_HEX0:   w = '{op: OP_LIT, lit: CHAR_ZERO, cond: C_NEVER,
                            target: STEP_ACCEPT};
         STEP_HEXX:   w = '{op: OP_LIT, lit: CHAR_X, cond: C_ALWAYS, target: STEP_DIGIT};
         default:     w = '{op: OP_NOP, lit: CHAR_ZERO, cond: C_ALWAYS,
                            target: STEP_ACCEPT};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### rtl/ifa_sequencer.sv
// step counter and control store lookup with conditional jumps
`timescale 1ns / 1ps
`default_nettype none

module ifa_sequencer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                rsp_ready,
   input  wire ifa_pkg::status_type status,
   output ifa_pkg::ctrl_type        ctrl,
   output logic                     req_ready,
   output logic                     rsp_valid
);

   logic [ifa_pkg::PC_W-1:0] pc_ff;
   logic [ifa_pkg::PC_W-1:0] pc_in;
   ifa_pkg::ucode_type       word;
   logic                     done;
   logic                     take;

   always_comb begin
      word = ifa_pkg::ucode_rom(pc_ff);
   end

   always_comb begin
      case (word.op)
         ifa_pkg::OP_ACCEPT: done = req_valid;
         ifa_pkg::OP_LIT,
         ifa_pkg::OP_DIGIT:  done = rsp_ready;
         default:            done = 1'b1;
      endcase
   end

   always_comb begin
      case (word.cond)
         ifa_pkg::C_NEVER:     take = 1'b0;
         ifa_pkg::C_ALWAYS:    take = 1'b1;
         ifa_pkg::C_HEX:       take = (status.action == ifa_pkg::ACT_HEX);
         ifa_pkg::C_BIN:       take = (status.action == ifa_pkg::ACT_BIN);
         ifa_pkg::C_FOUR:      take = (status.action == ifa_pkg::ACT_FOUR);
         ifa_pkg::C_POS:       take = !status.neg;
         ifa_pkg::C_MORE_ITER: take = !status.iter_last;
         ifa_pkg::C_NO_LEAD:   take = !status.lead_zero;
         ifa_pkg::C_MORE_DIG:  take = !status.count_one;
         default:              take = 1'b0;
      endcase
   end

   always_comb begin
      if (!done) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ifa_pkg::STEP_ACCEPT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      req_ready = (word.op == ifa_pkg::OP_ACCEPT);
      rsp_valid = (word.op == ifa_pkg::OP_LIT) || (word.op == ifa_pkg::OP_DIGIT);
      ctrl.op   = word.op;
      ctrl.lit  = word.lit;
      ctrl.fire = done;
   end

endmodule

`default_nettype wire

### rtl/ifa_datapath.sv
// operand, bcd and digit count registers with shift-add-3 and character select
`timescale 1ns / 1ps
`default_nettype none

module ifa_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ifa_pkg::ctrl_type   ctrl,
   input  wire ifa_pkg::req_type    req_payload,
   output ifa_pkg::status_type      status,
   output ifa_pkg::rsp_type         rsp_payload
);

   logic [ifa_pkg::VALUE_W-1:0] bin_ff, bin_in;
   logic [ifa_pkg::BCD_W-1:0]   bcd_ff, bcd_in;
   logic [ifa_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [ifa_pkg::ITER_W-1:0]  iter_ff, iter_in;
   ifa_pkg::action_type         action_ff, action_in;
   logic                        neg_ff, neg_in;

   logic [ifa_pkg::VALUE_W-1:0] raw;
   logic [ifa_pkg::BCD_W-1:0]   adj;
   logic [ifa_pkg::PAD_W-1:0]   padded;
   logic [ifa_pkg::COUNT_W-1:0] idx;
   logic [3:0]                  digit;
   logic [ifa_pkg::BCD_W-1:0]   bin_bcd;

   assign raw = ifa_pkg::VALUE_W'(req_payload.value);

   // binary mode: one bit per nibble, bit 7 in the highest used nibble
   always_comb begin
      bin_bcd = '0;
      for (int i = 0; i < ifa_pkg::BIN_DIGITS; i++) begin
         bin_bcd[4*i] = raw[i];
      end
   end

   // add 3 to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < ifa_pkg::NUM_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                    : bcd_ff[4*i +: 4];
      end
   end

   assign idx    = count_ff - 1'b1;
   assign padded = ifa_pkg::PAD_W'(bcd_ff);
   assign digit  = padded[{idx, 2'b00} +: 4];

   always_comb begin
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      count_in  = count_ff;
      iter_in   = iter_ff;
      action_in = action_ff;
      neg_in    = neg_ff;
      case (ctrl.op)
         ifa_pkg::OP_ACCEPT: begin
            if (ctrl.fire) begin
               action_in = ifa_pkg::action_type'(req_payload.action);
               iter_in   = '0;
               neg_in    = 1'b0;
               bcd_in    = '0;
               bin_in    = '0;
               case (ifa_pkg::action_type'(req_payload.action))
                  ifa_pkg::ACT_DEC: begin
                     neg_in   = raw[ifa_pkg::VALUE_W-1];
                     bin_in   = raw[ifa_pkg::VALUE_W-1] ? ~raw + 1'b1 : raw;
                     count_in = ifa_pkg::COUNT_W'(ifa_pkg::NUM_DIGITS);
                  end
                  ifa_pkg::ACT_BIN: begin
                     bcd_in   = bin_bcd;
                     count_in = ifa_pkg::COUNT_W'(ifa_pkg::BIN_DIGITS);
                  end
                  ifa_pkg::ACT_HEX: begin
                     bcd_in   = ifa_pkg::BCD_W'(raw[7:0]);
                     count_in = ifa_pkg::COUNT_W'(ifa_pkg::HEX_DIGITS);
                  end
                  default: begin
                     // keeping only the low four digits gives the mod 10000
                     bin_in   = ifa_pkg::VALUE_W'(raw[15:0]);
                     count_in = ifa_pkg::COUNT_W'(ifa_pkg::FOUR_DIGITS);
                  end
               endcase
            end
         end
         ifa_pkg::OP_DABBLE: begin
            {bcd_in, bin_in} = {adj[ifa_pkg::BCD_W-2:0], bin_ff, 1'b0};
            iter_in          = iter_ff + 1'b1;
         end
         ifa_pkg::OP_TRIM: begin
            count_in = count_ff - 1'b1;
         end
         ifa_pkg::OP_DIGIT: begin
            if (ctrl.fire) begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         action_ff <= ifa_pkg::ACT_DEC;
         neg_ff    <= 1'b0;
         count_ff  <= '0;
         iter_ff   <= '0;
      end else begin
         action_ff <= action_in;
         neg_ff    <= neg_in;
         count_ff  <= count_in;
         iter_ff   <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   always_comb begin
      status.action    = action_ff;
      status.neg       = neg_ff;
      status.iter_last = (iter_ff == ifa_pkg::ITER_W'(ifa_pkg::VALUE_W - 1));
      status.lead_zero = (digit == 4'd0) && (count_ff > ifa_pkg::COUNT_W'(1));
      status.count_one = (count_ff == ifa_pkg::COUNT_W'(1));
   end

   always_comb begin
      if (ctrl.op == ifa_pkg::OP_LIT) begin
         rsp_payload.char_code = ctrl.lit;
      end else if (digit < 4'd10) begin
         rsp_payload.char_code = ifa_pkg::CHAR_ZERO + ifa_pkg::CHAR_W'(digit);
      end else begin
         rsp_payload.char_code = ifa_pkg::CHAR_HEX_OFS + ifa_pkg::CHAR_W'(digit);
      end
      rsp_payload.last_char = (ctrl.op == ifa_pkg::OP_DIGIT) && status.count_one;
   end

endmodule

`default_nettype wire

### rtl/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter
//
// req channel: one transfer carries a format selector (action) and a 32-bit
// value. rsp channel: one transfer per ascii character, most significant
// first, with last_char set on the final character of the text.
// formats: signed decimal without leading zeros, eight binary digits of the
// low byte, "0X" and two hex digits of the low byte, four decimal digits of
// (low 16 bits mod 10000).
// one number is handled at a time; req_ready is high only while the
// sequencer sits at its accept step.
// decimal forms run 32 shift-add-3 steps of the bcd converter; signed
// decimal then strips each leading zero with a check step and a trim step.
// binary and hex skip the bcd converter. digit characters go out one per
// cycle while rsp_ready is high.
// a stalled rsp_ready holds the current character and the whole sequence.
// reset returns the sequencer to its accept step; nothing is pending after it.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ifa_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ifa_pkg::rsp_type      rsp_payload
);

   ifa_pkg::ctrl_type   ctrl;
   ifa_pkg::status_type status;

   ifa_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .ctrl      (ctrl),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid)
   );

   ifa_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .req_payload (req_payload),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### rtl/ifa_checker.sv
// port level checks for the integer to ascii formatter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ifa_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire ifa_pkg::rsp_type rsp_payload
);

   // a held character stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp changed while stalled");

   // never accepting while a character is offered
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("req_ready high while a character is offered");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after a req transfer");

   // more characters follow a character without the last flag
   a_text_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last_char |=> !req_ready)
      else $error("text ended without last_char");

endmodule

bind integer_to_ascii_formatter ifa_checker u_ifa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

### tb/ascii_text_checker.sv
// watches both channels of the formatter, predicts each character and compares
`timescale 1ns / 1ps

module ascii_text_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ifa_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ifa_pkg::rsp_type rsp_payload,
   input  logic             end_check,
   output int               chars_pending,
   output int               error_total
);

   ifa_pkg::rsp_type expected_text[$];
   int               mismatch_count = 0;
   logic             leftover_seen  = 1'b0;

   initial begin
      chars_pending = 0;
      error_total   = 0;
   end

   function automatic logic [6:0] hex_char(input logic [3:0] nibble);
      if (nibble < 4'd10) begin
         return ifa_pkg::CHAR_ZERO + 7'(nibble);
      end
      return ifa_pkg::CHAR_HEX_OFS + 7'(nibble);
   endfunction

   // append the characters one number turns into
   function automatic void predict_text(input ifa_pkg::req_type item);
      logic [31:0]      raw;
      logic [31:0]      mag;
      logic [15:0]      n;
      logic [3:0]       digit_q[$];
      logic [6:0]       codes[$];
      ifa_pkg::rsp_type ch;
      raw = item.value;
      case (ifa_pkg::action_type'(item.action))
         ifa_pkg::ACT_DEC: begin
            if (raw == 32'd0) begin
               codes.push_back(ifa_pkg::CHAR_ZERO);
            end else begin
               mag = raw;
               // the most negative value negates to itself, read as unsigned
               if (raw[31]) begin
                  mag = -raw;
                  codes.push_back(ifa_pkg::CHAR_MINUS);
               end
               while (mag != 32'd0) begin
                  digit_q.push_front(4'(mag % 32'd10));
                  mag = mag / 32'd10;
               end
               foreach (digit_q[i]) codes.push_back(ifa_pkg::CHAR_ZERO + 7'(digit_q[i]));
            end
         end
         ifa_pkg::ACT_BIN: begin
            for (int i = 7; i >= 0; i--) codes.push_back(ifa_pkg::CHAR_ZERO + 7'(raw[i]));
         end
         ifa_pkg::ACT_HEX: begin
            codes.push_back(ifa_pkg::CHAR_ZERO);
            codes.push_back(ifa_pkg::CHAR_X);
            codes.push_back(hex_char(raw[7:4]));
            codes.push_back(hex_char(raw[3:0]));
         end
         default: begin
            n = 16'({16'd0, raw[15:0]} % 32'd10000);
            codes.push_back(ifa_pkg::CHAR_ZERO + 7'(n / 16'd1000));
            codes.push_back(ifa_pkg::CHAR_ZERO + 7'((n / 16'd100) % 16'd10));
            codes.push_back(ifa_pkg::CHAR_ZERO + 7'((n / 16'd10) % 16'd10));
            codes.push_back(ifa_pkg::CHAR_ZERO + 7'(n % 16'd10));
         end
      endcase
      foreach (codes[i]) begin
         ch.char_code = codes[i];
         ch.last_char = (i == codes.size() - 1);
         expected_text.push_back(ch);
      end
   endfunction

   always @(posedge clock) begin : watch
      ifa_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_text(req_payload);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               $error("unexpected character transfer: char_code %0h, last_char %0b",
                      rsp_payload.char_code, rsp_payload.last_char);
               mismatch_count++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_payload.char_code !== want.char_code) begin
                  $error("char_code mismatch: expected %0h, actual %0h",
                         want.char_code, rsp_payload.char_code);
                  mismatch_count++;
               end
               if (rsp_payload.last_char !== want.last_char) begin
                  $error("last_char mismatch: expected %0b, actual %0b",
                         want.last_char, rsp_payload.last_char);
                  mismatch_count++;
               end
            end
         end
         if (end_check && !leftover_seen && expected_text.size() != 0) begin
            $error("%0d expected characters never arrived", expected_text.size());
            mismatch_count++;
            leftover_seen = 1'b1;
         end
      end
      chars_pending <= expected_text.size();
      error_total   <= mismatch_count;
   end

endmodule

### tb/integer_to_ascii_formatter_tb.sv
// stimulus and verdict for the integer to ascii formatter
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;

   localparam int RANDOM_ITEMS = 387;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   ifa_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   ifa_pkg::rsp_type rsp_payload;
   logic             end_check   = 1'b0;
   int               chars_pending;
   int               error_total;

   int burst_left = 0;
   int ready_mode = 0;
   int mode_cycles = 0;

   always #5 clock = ~clock;

   integer_to_ascii_formatter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   ascii_text_checker u_text_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .end_check     (end_check),
      .chars_pending (chars_pending),
      .error_total   (error_total)
   );

   // receiver: runs of full rate, coin-flip and sparse acceptance
   always @(posedge clock) begin
      if (mode_cycles == 0) begin
         ready_mode  = $urandom_range(0, 2);
         mode_cycles = $urandom_range(20, 200);
      end
      mode_cycles--;
      case (ready_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // sender works in bursts; valid is only lowered for a gap or a drain
   task automatic send_item(input logic [1:0] act, input logic [31:0] val);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= '{action: act, value: val};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_text();
      req_valid <= 1'b0;
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
   endtask

   // mix of short, long, signed, boundary and power-of-ten numbers
   function automatic logic [31:0] random_operand();
      logic [31:0] v;
      logic [31:0] p;
      case ($urandom_range(0, 9))
         0: v = $urandom_range(0, 9);
         1: v = -32'($urandom_range(1, 99));
         2: begin
            p = 32'd1;
            repeat ($urandom_range(0, 9)) p = p * 32'd10;
            v = p + 32'($urandom_range(0, 2)) - 32'd1;
            if ($urandom_range(0, 1) == 1) v = -v;
         end
         3: begin
            case ($urandom_range(0, 4))
               0:       v = 32'h0000_0000;
               1:       v = 32'h7FFF_FFFF;
               2:       v = 32'h8000_0000;
               3:       v = 32'h8000_0001;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
         4: v = $urandom_range(0, 65535);
         5: v = {16'($urandom_range(0, 65535)), 16'($urandom_range(9990, 10010))};
         default: v = $urandom();
      endcase
      return v;
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(ifa_pkg::ACT_DEC, 32'd0);
      send_item(ifa_pkg::ACT_DEC, 32'd1);
      send_item(ifa_pkg::ACT_DEC, 32'hFFFF_FFFF);
      send_item(ifa_pkg::ACT_DEC, 32'd9);
      send_item(ifa_pkg::ACT_DEC, 32'd10);
      send_item(ifa_pkg::ACT_DEC, 32'h7FFF_FFFF);
      send_item(ifa_pkg::ACT_DEC, 32'h8000_0000);
      send_item(ifa_pkg::ACT_DEC, 32'd1000000000);
      send_item(ifa_pkg::ACT_DEC, -32'd1000000000);
      send_item(ifa_pkg::ACT_BIN, 32'h0000_0000);
      send_item(ifa_pkg::ACT_BIN, 32'h0000_00FF);
      send_item(ifa_pkg::ACT_BIN, 32'hFFFF_FF5A);
      send_item(ifa_pkg::ACT_BIN, 32'h8000_0001);
      send_item(ifa_pkg::ACT_HEX, 32'h0000_0000);
      send_item(ifa_pkg::ACT_HEX, 32'hFFFF_FFFF);
      send_item(ifa_pkg::ACT_HEX, 32'h1234_5609);
      send_item(ifa_pkg::ACT_HEX, 32'h0000_00AB);
      send_item(ifa_pkg::ACT_FOUR, 32'd0);
      send_item(ifa_pkg::ACT_FOUR, 32'd9999);
      send_item(ifa_pkg::ACT_FOUR, 32'd10000);
      send_item(ifa_pkg::ACT_FOUR, 32'd65535);
      send_item(ifa_pkg::ACT_FOUR, 32'hFFFF_270F);
      send_item(ifa_pkg::ACT_FOUR, 32'h7FFF_0000);
      drain_text();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) begin
            drain_text();
         end
         send_item(2'($urandom_range(0, 3)), random_operand());
      end
      drain_text();

      // let any late character show up before the leftover check
      repeat (60) @(posedge clock);
      end_check <= 1'b1;
      repeat (2) @(posedge clock);
      if (error_total == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

### sim.f
rtl/ifa_pkg.sv
rtl/ifa_sequencer.sv
rtl/ifa_datapath.sv
rtl/integer_to_ascii_formatter.sv
rtl/ifa_checker.sv
tb/ascii_text_checker.sv
tb/integer_to_ascii_formatter_tb.sv
